// ===== rtl/core/rbs_pkg.sv =====
// shared types, widths and register codes of the ray/box slab intersector
`default_nettype none

package rbs_pkg;

  localparam int unsigned CoordW     = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DistW      = 31;
  localparam int unsigned NormTop    = 29;
  localparam int unsigned NormW      = NormTop + 1;
  localparam int unsigned MagW       = CoordW + 1;
  localparam int unsigned TopW       = 6;
  localparam int unsigned SqW        = 2 * NormW;
  localparam int unsigned SumW       = SqW + 2;
  localparam int unsigned RootW      = 64;
  localparam int unsigned SqrtSteps  = 32;
  localparam int unsigned LenW       = NormW + 1;
  localparam int unsigned RemW       = LenW + 1;
  localparam int unsigned UnitW      = FracBits + 1;
  localparam int unsigned PlaneSteps = CoordW;
  localparam int unsigned ProdW      = UnitW + DistW;
  localparam int unsigned DirStages  = 6;
  localparam int unsigned RegIdxW    = 3;

  localparam logic [CoordW-1:0] CoordMin = {1'b1, {(CoordW - 1){1'b0}}};
  localparam logic [CoordW-1:0] CoordMax = {1'b0, {(CoordW - 1){1'b1}}};

  typedef enum logic [RegIdxW-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } rbs_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] toward_x;
    logic signed [CoordW-1:0] toward_y;
    logic signed [CoordW-1:0] toward_z;
    logic [DistW-1:0]         max_distance;
  } rbs_in_t;

  typedef struct packed {
    logic                     hit;
    logic [DistW-1:0]         entry_distance;
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
    logic signed [CoordW-1:0] hit_z;
  } rbs_out_t;

  // ray origin, length limit and direction signs, carried down the pipe
  typedef struct packed {
    logic [2:0][CoordW-1:0] p;
    logic [DistW-1:0]       maxd;
    logic [2:0]             neg;
  } rbs_ray_t;

  typedef logic [2:0][CoordW-1:0] rbs_box_t;

endpackage

`default_nettype wire

// ===== rtl/core/rbs_dir.sv =====
// direction difference, normalising shift and sum of squares
`default_nettype none

module rbs_dir (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  rbs_pkg::rbs_in_t                       word_i,
  output logic                                   valid_o,
  output logic [rbs_pkg::SumW-1:0]               sum_o,
  output logic [2:0][rbs_pkg::NormW-1:0]         dm_o,
  output logic                                   zero_o,
  output rbs_pkg::rbs_ray_t                      ray_o
);

  logic [rbs_pkg::DirStages-1:0] v_q;

  logic [2:0][rbs_pkg::CoordW-1:0] st, tw;
  logic [2:0][rbs_pkg::MagW-1:0]   diff, mag1_d;
  logic [2:0]                      neg1_d;

  rbs_pkg::rbs_ray_t ray1_q, ray2_q, ray3_q, ray4_q, ray5_q, ray6_q;
  logic [2:0][rbs_pkg::MagW-1:0]  mag1_q, mag2_q, mag3_q;
  logic [rbs_pkg::MagW-1:0]       m2_d, m2_q;
  logic [rbs_pkg::TopW-1:0]       top3_d, top3_q;
  logic                           zero3_q, zero4_q, zero5_q, zero6_q;
  logic [2:0][rbs_pkg::NormW-1:0] dm4_d, dm4_q, dm5_q, dm6_q;
  logic [2:0][rbs_pkg::SqW-1:0]   sq5_d, sq5_q;
  logic [rbs_pkg::SumW-1:0]       sum6_d, sum6_q;

  assign st = {word_i.start_z, word_i.start_y, word_i.start_x};
  assign tw = {word_i.toward_z, word_i.toward_y, word_i.toward_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]   = {tw[i][rbs_pkg::CoordW-1], tw[i]} - {st[i][rbs_pkg::CoordW-1], st[i]};
      neg1_d[i] = diff[i][rbs_pkg::MagW-1];
      mag1_d[i] = neg1_d[i] ? rbs_pkg::MagW'(0) - diff[i] : diff[i];
    end
  end

  always_comb begin
    m2_d = mag1_q[0];
    if (mag1_q[1] > m2_d) begin
      m2_d = mag1_q[1];
    end
    if (mag1_q[2] > m2_d) begin
      m2_d = mag1_q[2];
    end
  end

  // leading one of the largest magnitude
  always_comb begin
    top3_d = '0;
    for (int b = 0; b < rbs_pkg::MagW; b++) begin
      if (m2_q[b]) begin
        top3_d = rbs_pkg::TopW'(b);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (top3_q > rbs_pkg::TopW'(rbs_pkg::NormTop)) begin
        dm4_d[i] = rbs_pkg::NormW'(mag3_q[i] >> (top3_q - rbs_pkg::TopW'(rbs_pkg::NormTop)));
      end else begin
        dm4_d[i] = rbs_pkg::NormW'(mag3_q[i] << (rbs_pkg::TopW'(rbs_pkg::NormTop) - top3_q));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq5_d[i] = rbs_pkg::SqW'(dm4_q[i]) * rbs_pkg::SqW'(dm4_q[i]);
    end
    sum6_d = rbs_pkg::SumW'(sq5_q[0]) + rbs_pkg::SumW'(sq5_q[1]) + rbs_pkg::SumW'(sq5_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[rbs_pkg::DirStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ray1_q.p    <= st;
      ray1_q.maxd <= word_i.max_distance;
      ray1_q.neg  <= neg1_d;
      mag1_q      <= mag1_d;
      ray2_q      <= ray1_q;
      mag2_q      <= mag1_q;
      m2_q        <= m2_d;
      ray3_q      <= ray2_q;
      mag3_q      <= mag2_q;
      top3_q      <= top3_d;
      zero3_q     <= (m2_q == '0);
      ray4_q      <= ray3_q;
      zero4_q     <= zero3_q;
      dm4_q       <= dm4_d;
      ray5_q      <= ray4_q;
      zero5_q     <= zero4_q;
      dm5_q       <= dm4_q;
      sq5_q       <= sq5_d;
      ray6_q      <= ray5_q;
      zero6_q     <= zero5_q;
      dm6_q       <= dm5_q;
      sum6_q      <= sum6_d;
    end
  end

  assign valid_o = v_q[rbs_pkg::DirStages-1];
  assign sum_o   = sum6_q;
  assign dm_o    = dm6_q;
  assign zero_o  = zero6_q;
  assign ray_o   = ray6_q;

endmodule

`default_nettype wire

// ===== rtl/core/rbs_unit.sv =====
// pipelined square root and per-axis division giving the unit direction
`default_nettype none

module rbs_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [rbs_pkg::SumW-1:0]           sum_i,
  input  logic [2:0][rbs_pkg::NormW-1:0]     dm_i,
  input  logic                               zero_i,
  input  rbs_pkg::rbs_ray_t                  ray_i,
  output logic                               valid_o,
  output logic [2:0][rbs_pkg::UnitW-1:0]     umag_o,
  output rbs_pkg::rbs_ray_t                  ray_o
);

  localparam int unsigned SqL  = rbs_pkg::SqrtSteps - 1;
  localparam int unsigned DivL = rbs_pkg::UnitW - 1;

  // square root stages
  logic [rbs_pkg::SqrtSteps-1:0]       sv_q;
  logic [rbs_pkg::RootW-1:0]           sx_in [rbs_pkg::SqrtSteps];
  logic [rbs_pkg::RootW-1:0]           sr_in [rbs_pkg::SqrtSteps];
  logic [rbs_pkg::RootW-1:0]           sx_d  [rbs_pkg::SqrtSteps];
  logic [rbs_pkg::RootW-1:0]           sr_d  [rbs_pkg::SqrtSteps];
  logic [rbs_pkg::RootW-1:0]           sx_q  [rbs_pkg::SqrtSteps];
  logic [rbs_pkg::RootW-1:0]           sr_q  [rbs_pkg::SqrtSteps];
  logic [2:0][rbs_pkg::NormW-1:0]      sdm_in [rbs_pkg::SqrtSteps];
  logic [2:0][rbs_pkg::NormW-1:0]      sdm_q  [rbs_pkg::SqrtSteps];
  logic                                szero_in [rbs_pkg::SqrtSteps];
  logic                                szero_q  [rbs_pkg::SqrtSteps];
  rbs_pkg::rbs_ray_t                   sray_in [rbs_pkg::SqrtSteps];
  rbs_pkg::rbs_ray_t                   sray_q  [rbs_pkg::SqrtSteps];

  // division stages
  logic [rbs_pkg::UnitW-1:0]           dv_q;
  logic [2:0][rbs_pkg::RemW-1:0]       drem_in [rbs_pkg::UnitW];
  logic [2:0][rbs_pkg::RemW-1:0]       drem_d  [rbs_pkg::UnitW];
  logic [2:0][rbs_pkg::RemW-1:0]       drem_q  [rbs_pkg::UnitW];
  logic [2:0][rbs_pkg::UnitW-1:0]      dq_in [rbs_pkg::UnitW];
  logic [2:0][rbs_pkg::UnitW-1:0]      dq_d  [rbs_pkg::UnitW];
  logic [2:0][rbs_pkg::UnitW-1:0]      dq_q  [rbs_pkg::UnitW];
  logic [2:0]                          dnb_in [rbs_pkg::UnitW];
  logic [rbs_pkg::LenW-1:0]            dlen_in [rbs_pkg::UnitW];
  logic [rbs_pkg::LenW-1:0]            dlen_q  [rbs_pkg::UnitW];
  logic                                dzero_in [rbs_pkg::UnitW];
  logic                                dzero_q  [rbs_pkg::UnitW];
  rbs_pkg::rbs_ray_t                   dray_in [rbs_pkg::UnitW];
  rbs_pkg::rbs_ray_t                   dray_q  [rbs_pkg::UnitW];

  always_comb begin
    logic [rbs_pkg::RootW-1:0] bval, trial;
    sx_in[0]    = rbs_pkg::RootW'(sum_i);
    sr_in[0]    = '0;
    sdm_in[0]   = dm_i;
    szero_in[0] = zero_i;
    sray_in[0]  = ray_i;
    for (int s = 1; s < rbs_pkg::SqrtSteps; s++) begin
      sx_in[s]    = sx_q[s-1];
      sr_in[s]    = sr_q[s-1];
      sdm_in[s]   = sdm_q[s-1];
      szero_in[s] = szero_q[s-1];
      sray_in[s]  = sray_q[s-1];
    end
    for (int s = 0; s < rbs_pkg::SqrtSteps; s++) begin
      bval  = rbs_pkg::RootW'(1) << (2 * (rbs_pkg::SqrtSteps - 1 - s));
      trial = sr_in[s] + bval;
      if (sx_in[s] >= trial) begin
        sx_d[s] = sx_in[s] - trial;
        sr_d[s] = (sr_in[s] >> 1) + bval;
      end else begin
        sx_d[s] = sx_in[s];
        sr_d[s] = sr_in[s] >> 1;
      end
    end
  end

  // restoring division of (dm << frac) by the length, one quotient bit a stage
  always_comb begin
    logic [rbs_pkg::RemW-1:0] t;
    logic                     ge;
    for (int i = 0; i < 3; i++) begin
      drem_in[0][i] = rbs_pkg::RemW'(sdm_q[SqL][i] >> 1);
      dnb_in[0][i]  = sdm_q[SqL][i][0];
    end
    dq_in[0]    = '0;
    dlen_in[0]  = sr_q[SqL][rbs_pkg::LenW-1:0];
    dzero_in[0] = szero_q[SqL];
    dray_in[0]  = sray_q[SqL];
    for (int j = 1; j < rbs_pkg::UnitW; j++) begin
      drem_in[j]  = drem_q[j-1];
      dnb_in[j]   = '0;
      dq_in[j]    = dq_q[j-1];
      dlen_in[j]  = dlen_q[j-1];
      dzero_in[j] = dzero_q[j-1];
      dray_in[j]  = dray_q[j-1];
    end
    for (int j = 0; j < rbs_pkg::UnitW; j++) begin
      for (int i = 0; i < 3; i++) begin
        t  = {drem_in[j][i][rbs_pkg::RemW-2:0], dnb_in[j][i]};
        ge = (t >= rbs_pkg::RemW'(dlen_in[j]));
        drem_d[j][i] = ge ? t - rbs_pkg::RemW'(dlen_in[j]) : t;
        dq_d[j][i]   = {dq_in[j][i][rbs_pkg::UnitW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
      dv_q <= '0;
    end else if (en_i) begin
      sv_q <= {sv_q[rbs_pkg::SqrtSteps-2:0], valid_i};
      dv_q <= {dv_q[rbs_pkg::UnitW-2:0], sv_q[SqL]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q    <= sx_d;
      sr_q    <= sr_d;
      sdm_q   <= sdm_in;
      szero_q <= szero_in;
      sray_q  <= sray_in;
      drem_q  <= drem_d;
      dq_q    <= dq_d;
      dlen_q  <= dlen_in;
      dzero_q <= dzero_in;
      dray_q  <= dray_in;
    end
  end

  assign valid_o = dv_q[DivL];
  assign umag_o  = dzero_q[DivL] ? '0 : dq_q[DivL];
  assign ray_o   = dray_q[DivL];

endmodule

`default_nettype wire

// ===== rtl/core/rbs_slab.sv =====
// plane distances per slab and the entry/exit interval fold
`default_nettype none

module rbs_slab (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [2:0][rbs_pkg::UnitW-1:0]     umag_i,
  input  rbs_pkg::rbs_ray_t                  ray_i,
  input  rbs_pkg::rbs_box_t                  box_min_i,
  input  rbs_pkg::rbs_box_t                  box_max_i,
  output logic                               valid_o,
  output logic                               hit_o,
  output logic [rbs_pkg::DistW-1:0]          tmin_o,
  output logic [2:0][rbs_pkg::UnitW-1:0]     umag_o,
  output rbs_pkg::rbs_ray_t                  ray_o
);

  localparam int unsigned NS = rbs_pkg::PlaneSteps;
  localparam int unsigned CW = rbs_pkg::CoordW;
  localparam int unsigned UW = rbs_pkg::UnitW;

  // lane k = 3 * plane + axis, plane 0 is the lower bound
  logic                      pv_q;
  logic [5:0][UW-1:0]        prem_d, prem_q;
  logic [5:0][CW-1:0]        plo_d, plo_q;
  logic [5:0]                povf_d, povf_q, psn_d, psn_q;
  logic [2:0]                ppar_d, ppar_q;
  logic                      ppm_d, ppm_q;
  rbs_pkg::rbs_ray_t         pray_q;
  logic [2:0][UW-1:0]        pumag_q;

  logic [NS-1:0]             qv_q;
  logic [5:0][UW-1:0]        qrem_in [NS];
  logic [5:0][UW-1:0]        qrem_d  [NS];
  logic [5:0][UW-1:0]        qrem_q  [NS];
  logic [5:0][CW-1:0]        qlo_in [NS];
  logic [5:0][CW-1:0]        qlo_q  [NS];
  logic [5:0][CW-1:0]        qq_in [NS];
  logic [5:0][CW-1:0]        qq_d  [NS];
  logic [5:0][CW-1:0]        qq_q  [NS];
  logic [5:0]                qovf_in [NS];
  logic [5:0]                qovf_q  [NS];
  logic [5:0]                qsn_in [NS];
  logic [5:0]                qsn_q  [NS];
  logic [2:0]                qpar_in [NS];
  logic [2:0]                qpar_q  [NS];
  logic                      qpm_in [NS];
  logic                      qpm_q  [NS];
  rbs_pkg::rbs_ray_t         qray_in [NS];
  rbs_pkg::rbs_ray_t         qray_q  [NS];
  logic [2:0][UW-1:0]        qumag_in [NS];
  logic [2:0][UW-1:0]        qumag_q  [NS];

  logic                      tv_q, ov_q, fv_q, hv_q;
  logic [5:0][CW-1:0]        tt_d, tt_q;
  logic [2:0]                tpar_q, opar_q;
  logic                      tpm_q, opm_q, fpm_q;
  rbs_pkg::rbs_ray_t         tray_q, oray_q, fray_q, hray_q;
  logic [2:0][UW-1:0]        tumag_q, oumag_q, fumag_q, humag_q;
  logic [2:0][CW-1:0]        olo_d, olo_q, ohi_d, ohi_q;
  logic signed [CW-1:0]      fmin_d, fmin_q, fmax_d, fmax_q;
  logic                      hhit_q;
  logic [rbs_pkg::DistW-1:0] htmin_q;

  always_comb begin
    logic [CW-1:0]             bound;
    logic [rbs_pkg::MagW-1:0]  num, nmag;
    logic [2:0]                outside;
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < 3; i++) begin
        bound = (b == 0) ? box_min_i[i] : box_max_i[i];
        num   = {bound[CW-1], bound} - {ray_i.p[i][CW-1], ray_i.p[i]};
        nmag  = num[rbs_pkg::MagW-1] ? rbs_pkg::MagW'(0) - num : num;
        povf_d[3*b+i] = nmag >= {umag_i[i], {rbs_pkg::FracBits{1'b0}}};
        psn_d[3*b+i]  = num[rbs_pkg::MagW-1] ^ ray_i.neg[i];
        prem_d[3*b+i] = UW'({nmag, {rbs_pkg::FracBits{1'b0}}} >> CW);
        plo_d[3*b+i]  = CW'({nmag, {rbs_pkg::FracBits{1'b0}}});
      end
    end
    for (int i = 0; i < 3; i++) begin
      ppar_d[i]  = (umag_i[i] == '0);
      outside[i] = ($signed(ray_i.p[i]) < $signed(box_min_i[i])) ||
                   ($signed(ray_i.p[i]) > $signed(box_max_i[i]));
    end
    ppm_d = |(ppar_d & outside);
  end

  // restoring division (|num| << frac) / |u|, low word of quotient
  always_comb begin
    logic [UW:0] t;
    logic        ge;
    qrem_in[0]  = prem_q;
    qlo_in[0]   = plo_q;
    qq_in[0]    = '0;
    qovf_in[0]  = povf_q;
    qsn_in[0]   = psn_q;
    qpar_in[0]  = ppar_q;
    qpm_in[0]   = ppm_q;
    qray_in[0]  = pray_q;
    qumag_in[0] = pumag_q;
    for (int s = 1; s < NS; s++) begin
      qrem_in[s]  = qrem_q[s-1];
      qlo_in[s]   = qlo_q[s-1];
      qq_in[s]    = qq_q[s-1];
      qovf_in[s]  = qovf_q[s-1];
      qsn_in[s]   = qsn_q[s-1];
      qpar_in[s]  = qpar_q[s-1];
      qpm_in[s]   = qpm_q[s-1];
      qray_in[s]  = qray_q[s-1];
      qumag_in[s] = qumag_q[s-1];
    end
    for (int s = 0; s < NS; s++) begin
      for (int k = 0; k < 6; k++) begin
        t  = {qrem_in[s][k], qlo_in[s][k][CW-1]};
        ge = (t >= {1'b0, qumag_in[s][k % 3]});
        qrem_d[s][k] = ge ? UW'(t - {1'b0, qumag_in[s][k % 3]}) : UW'(t);
        qq_d[s][k]   = {qq_in[s][k][CW-2:0], ge};
      end
    end
  end

  // saturate to signed coordinate range
  always_comb begin
    logic [CW-1:0] q;
    for (int k = 0; k < 6; k++) begin
      q = qq_q[NS-1][k];
      if (qsn_q[NS-1][k]) begin
        tt_d[k] = (qovf_q[NS-1][k] || q > rbs_pkg::CoordMin) ? rbs_pkg::CoordMin : CW'(0) - q;
      end else begin
        tt_d[k] = (qovf_q[NS-1][k] || q[CW-1]) ? rbs_pkg::CoordMax : q;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if ($signed(tt_q[i]) > $signed(tt_q[i+3])) begin
        olo_d[i] = tt_q[i+3];
        ohi_d[i] = tt_q[i];
      end else begin
        olo_d[i] = tt_q[i];
        ohi_d[i] = tt_q[i+3];
      end
    end
  end

  always_comb begin
    fmin_d = '0;
    fmax_d = CW'(oray_q.maxd);
    for (int i = 0; i < 3; i++) begin
      if (!opar_q[i]) begin
        if ($signed(olo_q[i]) > fmin_d) begin
          fmin_d = olo_q[i];
        end
        if ($signed(ohi_q[i]) < fmax_d) begin
          fmax_d = ohi_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      qv_q <= '0;
      tv_q <= 1'b0;
      ov_q <= 1'b0;
      fv_q <= 1'b0;
      hv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
      qv_q <= {qv_q[NS-2:0], pv_q};
      tv_q <= qv_q[NS-1];
      ov_q <= tv_q;
      fv_q <= ov_q;
      hv_q <= fv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prem_q  <= prem_d;
      plo_q   <= plo_d;
      povf_q  <= povf_d;
      psn_q   <= psn_d;
      ppar_q  <= ppar_d;
      ppm_q   <= ppm_d;
      pray_q  <= ray_i;
      pumag_q <= umag_i;
      qrem_q  <= qrem_d;
      qq_q    <= qq_d;
      for (int s = 0; s < NS; s++) begin
        for (int k = 0; k < 6; k++) begin
          qlo_q[s][k] <= {qlo_in[s][k][CW-2:0], 1'b0};
        end
      end
      qovf_q  <= qovf_in;
      qsn_q   <= qsn_in;
      qpar_q  <= qpar_in;
      qpm_q   <= qpm_in;
      qray_q  <= qray_in;
      qumag_q <= qumag_in;
      tt_q    <= tt_d;
      tpar_q  <= qpar_q[NS-1];
      tpm_q   <= qpm_q[NS-1];
      tray_q  <= qray_q[NS-1];
      tumag_q <= qumag_q[NS-1];
      olo_q   <= olo_d;
      ohi_q   <= ohi_d;
      opar_q  <= tpar_q;
      opm_q   <= tpm_q;
      oray_q  <= tray_q;
      oumag_q <= tumag_q;
      fmin_q  <= fmin_d;
      fmax_q  <= fmax_d;
      fpm_q   <= opm_q;
      fray_q  <= oray_q;
      fumag_q <= oumag_q;
      hhit_q  <= !fpm_q && (fmin_q <= fmax_q);
      htmin_q <= fmin_q[rbs_pkg::DistW-1:0];
      hray_q  <= fray_q;
      humag_q <= fumag_q;
    end
  end

  assign valid_o = hv_q;
  assign hit_o   = hhit_q;
  assign tmin_o  = htmin_q;
  assign umag_o  = humag_q;
  assign ray_o   = hray_q;

endmodule

`default_nettype wire

// ===== rtl/core/rbs_hit.sv =====
// entry point along the unit direction and the output word register
`default_nettype none

module rbs_hit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic                               hit_i,
  input  logic [rbs_pkg::DistW-1:0]          tmin_i,
  input  logic [2:0][rbs_pkg::UnitW-1:0]     umag_i,
  input  rbs_pkg::rbs_ray_t                  ray_i,
  output logic                               valid_o,
  output rbs_pkg::rbs_out_t                  word_o
);

  localparam int unsigned CW = rbs_pkg::CoordW;

  logic                              mv_q, ov_q;
  logic [2:0][rbs_pkg::ProdW-1:0]    prod_d, prod_q;
  logic                              mhit_q;
  logic [rbs_pkg::DistW-1:0]         mtmin_q;
  rbs_pkg::rbs_ray_t                 mray_q;
  logic [2:0][CW-1:0]                h_d;
  rbs_pkg::rbs_out_t                 word_d, word_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = rbs_pkg::ProdW'(umag_i[i]) * rbs_pkg::ProdW'(tmin_i);
    end
  end

  always_comb begin
    logic [CW-1:0] off;
    logic [CW+1:0] s;
    for (int i = 0; i < 3; i++) begin
      off = CW'(prod_q[i] >> rbs_pkg::FracBits);
      if (mray_q.neg[i]) begin
        s = {{2{mray_q.p[i][CW-1]}}, mray_q.p[i]} - {2'b00, off};
      end else begin
        s = {{2{mray_q.p[i][CW-1]}}, mray_q.p[i]} + {2'b00, off};
      end
      if (s[CW+1:CW-1] == 3'b000 || s[CW+1:CW-1] == 3'b111) begin
        h_d[i] = s[CW-1:0];
      end else if (s[CW+1]) begin
        h_d[i] = rbs_pkg::CoordMin;
      end else begin
        h_d[i] = rbs_pkg::CoordMax;
      end
    end
    if (mhit_q) begin
      word_d.hit            = 1'b1;
      word_d.entry_distance = mtmin_q;
      word_d.hit_x          = h_d[0];
      word_d.hit_y          = h_d[1];
      word_d.hit_z          = h_d[2];
    end else begin
      word_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en_i) begin
      mv_q <= valid_i;
      ov_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      mhit_q  <= hit_i;
      mtmin_q <= tmin_i;
      mray_q  <= ray_i;
      word_q  <= word_d;
    end
  end

  assign valid_o = ov_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

// ===== rtl/core/ray_box_slab_intersect.sv =====
// top level: box registers, pipeline enable and the four pipeline sections
// throughput: one word per cycle; a new ray enters every cycle while the output moves
// a held output word freezes every stage, so in_stall_o follows out_stall_i while out_valid_o is high
// stages: 6 direction, 32 square root, 17 unit divide, 37 slab divide and fold, 2 entry point
// reset: all stage valid bits clear and the six box bounds return to zero
`default_nettype none

module ray_box_slab_intersect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rbs_pkg::rbs_in_t              in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rbs_pkg::rbs_out_t             out_word_o,
  input  logic                          cfg_we_i,
  input  logic [rbs_pkg::RegIdxW-1:0]   cfg_index_i,
  input  logic [rbs_pkg::CoordW-1:0]    cfg_data_i
);

  logic                               en;
  rbs_pkg::rbs_box_t                  box_min_q, box_max_q;

  logic                               dir_valid, dir_zero;
  logic [rbs_pkg::SumW-1:0]           dir_sum;
  logic [2:0][rbs_pkg::NormW-1:0]     dir_dm;
  rbs_pkg::rbs_ray_t                  dir_ray;

  logic                               unit_valid;
  logic [2:0][rbs_pkg::UnitW-1:0]     unit_umag;
  rbs_pkg::rbs_ray_t                  unit_ray;

  logic                               slab_valid, slab_hit;
  logic [rbs_pkg::DistW-1:0]          slab_tmin;
  logic [2:0][rbs_pkg::UnitW-1:0]     slab_umag;
  rbs_pkg::rbs_ray_t                  slab_ray;

  assign in_stall_o = out_valid_o & out_stall_i;
  assign en         = ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min_q <= '0;
      box_max_q <= '0;
    end else if (cfg_we_i) begin
      unique case (rbs_pkg::rbs_reg_e'(cfg_index_i))
        rbs_pkg::REG_MIN_X: box_min_q[0] <= cfg_data_i;
        rbs_pkg::REG_MIN_Y: box_min_q[1] <= cfg_data_i;
        rbs_pkg::REG_MIN_Z: box_min_q[2] <= cfg_data_i;
        rbs_pkg::REG_MAX_X: box_max_q[0] <= cfg_data_i;
        rbs_pkg::REG_MAX_Y: box_max_q[1] <= cfg_data_i;
        rbs_pkg::REG_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rbs_dir u_dir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .word_i  (in_word_i),
    .valid_o (dir_valid),
    .sum_o   (dir_sum),
    .dm_o    (dir_dm),
    .zero_o  (dir_zero),
    .ray_o   (dir_ray)
  );

  rbs_unit u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dir_valid),
    .sum_i   (dir_sum),
    .dm_i    (dir_dm),
    .zero_i  (dir_zero),
    .ray_i   (dir_ray),
    .valid_o (unit_valid),
    .umag_o  (unit_umag),
    .ray_o   (unit_ray)
  );

  rbs_slab u_slab (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (unit_valid),
    .umag_i    (unit_umag),
    .ray_i     (unit_ray),
    .box_min_i (box_min_q),
    .box_max_i (box_max_q),
    .valid_o   (slab_valid),
    .hit_o     (slab_hit),
    .tmin_o    (slab_tmin),
    .umag_o    (slab_umag),
    .ray_o     (slab_ray)
  );

  rbs_hit u_hit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (slab_valid),
    .hit_i   (slab_hit),
    .tmin_i  (slab_tmin),
    .umag_i  (slab_umag),
    .ray_i   (slab_ray),
    .valid_o (out_valid_o),
    .word_o  (out_word_o)
  );

  // a missed ray carries an all-zero word
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.hit |->
      out_word_o.entry_distance == '0 && out_word_o.hit_x == '0 &&
      out_word_o.hit_y == '0 && out_word_o.hit_z == '0)
    else $error("miss word not cleared");

  // the pipe only holds when a finished word is refused
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input held without a refused output word");

  a_cfg_max_z : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_index_i == rbs_pkg::REG_MAX_Z |=> box_max_q[2] == $past(cfg_data_i))
    else $error("upper z bound not written");

  a_cfg_min_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_index_i == rbs_pkg::REG_MIN_X |=> box_min_q[0] == $past(cfg_data_i))
    else $error("lower x bound not written");

endmodule

`default_nettype wire
